### sv/lrf_pkg.sv
// shared types and codes for the lockable register file
package lrf_pkg;

  localparam int DATA_W   = 8;
  localparam int ADDR_W   = 8;
  localparam int ACTION_W = 3;
  localparam int CLASS_W  = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  // access codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_READ          = 3'd0,
    ACT_WRITE         = 3'd1,
    ACT_WRITE_OPEN    = 3'd2,
    ACT_INCR          = 3'd3,
    ACT_GET_CHANGED   = 3'd4,
    ACT_CLEAR_CHANGED = 3'd5,
    ACT_SET_CLASS     = 3'd6
  } act_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_RANGE  = 2'd1,
    ST_DENIED = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASTER_KEY = 1'd0,
    CFG_USER_KEY   = 1'd1
  } cfg_idx_t;

  // class bits: user-lockable wins over master-locked
  localparam int CLASS_MASTER_BIT = 0;
  localparam int CLASS_USER_BIT   = 1;

  // one stored register with its class and changed flag
  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic               chg;
    logic [DATA_W-1:0]  data;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic cnt_rd;
    logic cnt_wr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_bump;
  } sts_t;

endpackage

### sv/lrf_if.sv
// handshake channel interfaces for access beats, result beats and config writes
interface lrf_req_if import lrf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ADDR_W-1:0]   address;
  logic [DATA_W-1:0]   write_data;
  logic [CLASS_W-1:0]  access_class;

  modport source (output valid, action, address, write_data, access_class, input ready);
  modport sink   (input valid, action, address, write_data, access_class, output ready);
endinterface

interface lrf_rsp_if import lrf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   read_data;
  logic                changed;
  logic [STATUS_W-1:0] status;

  modport source (output valid, read_data, changed, status, input ready);
  modport sink   (input valid, read_data, changed, status, output ready);
endinterface

interface lrf_cfg_if import lrf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/lrf_ram.sv
// generic single write port ram with registered read
module lrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/lrf_ctrl.sv
// sequencing state machine for one access at a time
module lrf_ctrl import lrf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_CNT_RD = 5'b00100,
    S_CNT_WR = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (req_valid) state_next = S_EXEC;
      S_EXEC:   state_next = sts.need_bump ? S_CNT_RD : S_RESP;
      S_CNT_RD: state_next = S_CNT_WR;
      S_CNT_WR: state_next = S_RESP;
      S_RESP:   if (rsp_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready   = (state == S_IDLE);
  assign rsp_valid   = (state == S_RESP);
  assign cmd.capture = (state == S_IDLE) && req_valid;
  assign cmd.exec    = (state == S_EXEC);
  assign cmd.cnt_rd  = (state == S_CNT_RD);
  assign cmd.cnt_wr  = (state == S_CNT_WR);

endmodule

### sv/lrf_dp.sv
// register store, lock checks, counters and result registers
module lrf_dp import lrf_pkg::*; #(
  parameter int DEPTH             = 128,
  parameter int MASTER_LOCK_ADDR  = 1,
  parameter int USER_LOCK_ADDR    = 2,
  parameter int RANGE_COUNT_ADDR  = 3,
  parameter int DENIED_COUNT_ADDR = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [ACTION_W-1:0]  action,
  input  logic [ADDR_W-1:0]    address,
  input  logic [DATA_W-1:0]    write_data,
  input  logic [CLASS_W-1:0]   access_class,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output logic [DATA_W-1:0]    read_data,
  output logic                 changed,
  output logic [STATUS_W-1:0]  status
);

  localparam int AW  = $clog2(DEPTH);
  localparam int EW  = $bits(entry_t);
  localparam logic [AW-1:0] MLOCK_IDX  = AW'(MASTER_LOCK_ADDR);
  localparam logic [AW-1:0] ULOCK_IDX  = AW'(USER_LOCK_ADDR);
  localparam logic [AW-1:0] RANGE_IDX  = AW'(RANGE_COUNT_ADDR);
  localparam logic [AW-1:0] DENIED_IDX = AW'(DENIED_COUNT_ADDR);
  localparam bit MLOCK_OK  = MASTER_LOCK_ADDR < DEPTH;
  localparam bit ULOCK_OK  = USER_LOCK_ADDR < DEPTH;
  localparam bit RANGE_OK  = RANGE_COUNT_ADDR < DEPTH;
  localparam bit DENIED_OK = DENIED_COUNT_ADDR < DEPTH;

  // captured access
  logic [ACTION_W-1:0] action_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [DATA_W-1:0]   wdata_q;
  logic [CLASS_W-1:0]  cls_q;

  logic [DATA_W-1:0] master_key, user_key;
  logic [DATA_W-1:0] master_lock, user_lock;
  logic [DEPTH-1:0]  vld;
  logic              ent_vld_q;

  logic [AW-1:0] rd_addr, wr_addr, cnt_idx;
  logic [EW-1:0] ram_rd;
  entry_t        cur, nxt, cnt_ent, wr_ent;
  logic          wr_en, exec_wr, cnt_ok;
  logic          in_range, act_known, master_in, user_in, allowed;
  logic [DATA_W-1:0] rd_c;
  logic              chg_c;
  status_t           st_c;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_q <= action;
      addr_q   <= address;
      wdata_q  <= write_data;
      cls_q    <= access_class;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master_key <= '0;
      user_key   <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MASTER_KEY: master_key <= cfg_data;
        CFG_USER_KEY:   user_key   <= cfg_data;
        default: ;
      endcase
    end
  end

  // counter slot for the pending bump
  assign cnt_idx = (status_t'(status) == ST_RANGE) ? RANGE_IDX : DENIED_IDX;
  assign cnt_ok  = (status_t'(status) == ST_RANGE) ? RANGE_OK : DENIED_OK;
  assign rd_addr = cmd.cnt_rd ? cnt_idx : address[AW-1:0];

  lrf_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  // never-written entries read as reset value
  always_ff @(posedge clk) begin
    ent_vld_q <= vld[rd_addr];
  end
  assign cur = ent_vld_q ? entry_t'(ram_rd) : '0;

  assign in_range  = {1'b0, addr_q} < (ADDR_W + 1)'(DEPTH);
  assign act_known = action_q <= ACTION_W'(ACT_SET_CLASS);
  assign master_in = (master_lock == master_key);
  assign user_in   = (user_lock == user_key);

  always_comb begin
    if (cur.cls[CLASS_USER_BIT]) begin
      allowed = user_in || master_in;
    end else if (cur.cls[CLASS_MASTER_BIT]) begin
      allowed = master_in;
    end else begin
      allowed = 1'b1;
    end
  end

  always_comb begin
    rd_c    = '0;
    chg_c   = 1'b0;
    st_c    = ST_DONE;
    exec_wr = 1'b0;
    nxt     = cur;
    if (act_known) begin
      if (!in_range) begin
        st_c = ST_RANGE;
      end else begin
        case (act_t'(action_q))
          ACT_READ: rd_c = cur.data;
          ACT_WRITE, ACT_INCR: begin
            if (allowed) begin
              exec_wr  = 1'b1;
              nxt.data = (act_t'(action_q) == ACT_WRITE) ? wdata_q : cur.data + 8'd1;
              nxt.chg  = 1'b1;
            end else begin
              st_c = ST_DENIED;
            end
          end
          ACT_WRITE_OPEN: begin
            exec_wr  = 1'b1;
            nxt.data = wdata_q;
          end
          ACT_GET_CHANGED: chg_c = cur.chg;
          ACT_CLEAR_CHANGED: begin
            exec_wr = 1'b1;
            nxt.chg = 1'b0;
          end
          ACT_SET_CLASS: begin
            exec_wr = 1'b1;
            nxt.cls = cls_q;
          end
          default: ;
        endcase
      end
    end
  end

  assign sts.need_bump = (st_c != ST_DONE);

  always_comb begin
    cnt_ent      = cur;
    cnt_ent.data = cur.data + 8'd1;
    cnt_ent.chg  = 1'b1;
  end

  assign wr_en   = (cmd.exec && exec_wr) || (cmd.cnt_wr && cnt_ok);
  assign wr_addr = cmd.cnt_wr ? cnt_idx : addr_q[AW-1:0];
  assign wr_ent  = cmd.cnt_wr ? cnt_ent : nxt;

  // valid bits and lock register shadows follow every store write
  always_ff @(posedge clk) begin
    if (rst) begin
      vld         <= '0;
      master_lock <= '0;
      user_lock   <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
      if (MLOCK_OK && wr_addr == MLOCK_IDX) master_lock <= wr_ent.data;
      if (ULOCK_OK && wr_addr == ULOCK_IDX) user_lock   <= wr_ent.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= ST_DONE;
    end else if (cmd.exec) begin
      status <= st_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_data <= rd_c;
      changed   <= chg_c;
    end
  end

endmodule

### sv/lockable_register_file.sv
// a result beat is offered after the controller passes its execute state, and its counter
// read and write states when a bump is needed (range or denied); one access at a time,
// a new one is accepted only when idle again after the result beat is taken
// reset (rst, synchronous) clears keys, lock shadows, valid bits and the state
// machine; every register reads zero, open and unchanged until written
module lockable_register_file import lrf_pkg::*; #(
  parameter int DEPTH             = 128,
  parameter int MASTER_LOCK_ADDR  = 1,
  parameter int USER_LOCK_ADDR    = 2,
  parameter int RANGE_COUNT_ADDR  = 3,
  parameter int DENIED_COUNT_ADDR = 4
) (
  input logic   clk,
  input logic   rst,
  lrf_req_if.sink   req,
  lrf_rsp_if.source rsp,
  lrf_cfg_if.sink   cfg
);

  cmd_t cmd;
  sts_t sts;

  // config writes are always taken and registered when valid
  assign cfg.ready = 1'b1;

  // controller walks accept, execute, optional counter bump, then result beat
  lrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath holds the store, keys, lock shadows and result registers
  lrf_dp #(
    .DEPTH             (DEPTH),
    .MASTER_LOCK_ADDR  (MASTER_LOCK_ADDR),
    .USER_LOCK_ADDR    (USER_LOCK_ADDR),
    .RANGE_COUNT_ADDR  (RANGE_COUNT_ADDR),
    .DENIED_COUNT_ADDR (DENIED_COUNT_ADDR)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .action       (req.action),
    .address      (req.address),
    .write_data   (req.write_data),
    .access_class (req.access_class),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .read_data    (rsp.read_data),
    .changed      (rsp.changed),
    .status       (rsp.status)
  );

endmodule
